@@ rtl/ees_pkg.sv @@
`default_nettype none
package ees_pkg;
  localparam logic [63:0] NonceTag = 64'h454550524F4D3031;
  localparam logic [7:0] ErasedByte = 8'hFF;

  typedef enum logic [2:0] {
    RegKeyHigh  = 3'd0,
    RegKeyLow   = 3'd1,
    RegEncBase  = 3'd2,
    RegEncLen   = 3'd3,
    RegCntBase  = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StClear,
    StAes,
    StRead,
    StDone
  } state_e;

  typedef enum logic [1:0] {
    KindPlain,
    KindEnc,
    KindCounter
  } kind_e;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } aes_ctrl_t;

  function automatic logic [7:0] sbox(input logic [7:0] v);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[v];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // byte 0 is the most significant byte of the 128-bit word
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[127 - 8*(i + 4*c) -: 8] = sbox(s[127 - 8*(i + 4*((c + i) % 4)) -: 8]);
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] t);
    logic [127:0] o;
    logic [7:0] p0, p1, p2, p3, all;
    for (int c = 0; c < 4; c++) begin
      p0 = t[127 - 32*c -: 8];
      p1 = t[119 - 32*c -: 8];
      p2 = t[111 - 32*c -: 8];
      p3 = t[103 - 32*c -: 8];
      all = p0 ^ p1 ^ p2 ^ p3;
      o[127 - 32*c -: 8] = p0 ^ all ^ xt(p0 ^ p1);
      o[119 - 32*c -: 8] = p1 ^ all ^ xt(p1 ^ p2);
      o[111 - 32*c -: 8] = p2 ^ all ^ xt(p2 ^ p3);
      o[103 - 32*c -: 8] = p3 ^ all ^ xt(p3 ^ p0);
    end
    return o;
  endfunction

  function automatic logic [127:0] next_rk(input logic [127:0] k, input logic [7:0] rcon);
    logic [31:0] w0, w1, w2, w3, g;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    g = {sbox(w3[23:16]) ^ rcon, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ g;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction
endpackage
`default_nettype wire

@@ rtl/ees_aes.sv @@
`default_nettype none
// iterative AES-128: one round per cycle, key schedule on the fly
module ees_aes import ees_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [127:0] key_i,
  input  wire logic [127:0] block_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [127:0]      block_o
);
  logic [127:0] st_q, st_d, rk_q, rk_d;
  logic [7:0]   rcon_q, rcon_d;
  logic [3:0]   rnd_q, rnd_d;
  logic         busy_q, busy_d, done_q, done_d;
  logic [127:0] nk, ss;

  assign nk = next_rk(rk_q, rcon_q);
  assign ss = sub_shift(st_q);

  always_comb begin
    st_d = st_q;
    rk_d = rk_q;
    rcon_d = rcon_q;
    rnd_d = rnd_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i && !busy_q) begin
      st_d = block_i ^ key_i;
      rk_d = key_i;
      rcon_d = 8'h01;
      rnd_d = 4'd1;
      busy_d = 1'b1;
    end else if (busy_q) begin
      st_d = ((rnd_q == 4'd10) ? ss : mix_cols(ss)) ^ nk;
      rk_d = nk;
      rcon_d = xt(rcon_q);
      rnd_d = rnd_q + 4'd1;
      if (rnd_q == 4'd10) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rnd_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      rnd_q <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    rk_q <= rk_d;
    rcon_q <= rcon_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign block_o = st_q;

`ifndef NO_ASSERTIONS
  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q)) else $error("done without round run");
  a_round_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rnd_q >= 4'd1 && rnd_q <= 4'd10) else $error("round out of range");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_q) |=> busy_q) else $error("start lost");
`endif
endmodule
`default_nettype wire

@@ rtl/ees_mem.sv @@
`default_nettype none
// byte store, one port, registered read
module ees_mem import ees_pkg::*; #(
  parameter int AW = 14
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire logic [7:0]    wdata_i,
  output logic [7:0]         rdata_o
);
  logic [7:0] mem_q [2**AW];
  logic [7:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rd_q <= mem_q[addr_i];
  end

  assign rdata_o = rd_q;
endmodule
`default_nettype wire

@@ rtl/encrypted_eeprom_store_top.sv @@
`default_nettype none
// Channel | Dir | Signals
// command | in  | start, busy, command_i, start_address_i, byte_index_i, write_data_i, burst_last_i
// result  | out | result_valid_o, read_data_o, counter_incremented_o
// config  | in  | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i
//
// Encrypted bytes wait for the iterative AES core (one round a cycle). A burst
// end that bumps the counter adds four backing writes, one per counter byte.
// After reset a clearing pass writes 0xFF to every byte, with busy high.
// Config transfers are taken only while idle with start low.
// Results last one cycle on result_valid_o; the receiver cannot stall.
module encrypted_eeprom_store_top import ees_pkg::*; #(
  parameter int ADDR_BITS  = 14,
  parameter int PAGE_BYTES = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        command_i,
  input  wire logic [13:0] start_address_i,
  input  wire logic [5:0]  byte_index_i,
  input  wire logic [7:0]  write_data_i,
  input  wire logic        burst_last_i,
  output logic             result_valid_o,
  output logic [7:0]       read_data_o,
  output logic             counter_incremented_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);
  localparam int PW = $clog2(PAGE_BYTES);
  localparam int AW = ADDR_BITS;

  // configuration
  logic [63:0] key_hi_q, key_lo_q;
  logic [13:0] enc_base_q, cnt_base_q;
  logic [8:0]  enc_len_q;
  state_e      state_q, state_d;

  // no config change while an item is in flight or being offered
  assign cfg_ready_o = (state_q == StIdle) && !start;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
      enc_base_q <= '0;
      enc_len_q <= 9'd252;
      cnt_base_q <= 14'd16380;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegKeyHigh: key_hi_q <= cfg_data_i;
        RegKeyLow:  key_lo_q <= cfg_data_i;
        RegEncBase: enc_base_q <= cfg_data_i[13:0];
        RegEncLen:  enc_len_q <= cfg_data_i[8:0];
        RegCntBase: cnt_base_q <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  // address decode on the accepted item
  logic [AW-1:0] s_a, rd_a, pg_a, a_c;
  logic [PW-1:0] inpg, pg_off;
  logic [AW-1:0] coff_c, eoff_c;
  logic          use_c;
  kind_e         kind_c;

  assign s_a   = AW'(start_address_i);
  assign rd_a  = s_a + AW'(byte_index_i);
  assign inpg  = s_a[PW-1:0];
  assign pg_off = inpg + PW'(byte_index_i);
  assign pg_a  = {s_a[AW-1:PW], pg_off};
  assign a_c   = command_i ? pg_a : rd_a;
  assign use_c = !command_i || ({3'b0, byte_index_i} < 9'(PAGE_BYTES));
  assign coff_c = a_c - AW'(cnt_base_q);
  assign eoff_c = a_c - AW'(enc_base_q);
  always_comb begin
    if (coff_c < AW'(4)) kind_c = KindCounter;
    else if ({2'b0, eoff_c} < (AW + 2)'(enc_len_q)) kind_c = KindEnc;
    else kind_c = KindPlain;
  end

  // item registers
  logic        cmd_q, last_q, use_q;
  logic [AW-1:0] a_q, eoff_q;
  logic [1:0]  coff_q;
  logic [7:0]  wd_q;
  kind_e       kind_q;
  logic [AW:0] clr_q;
  logic [2:0]  bump_q;
  logic [31:0] evc_q;
  logic        touched_q;
  logic [7:0]  ks_q, rd_data_q;
  logic        res_q, inc_q;
  logic        ks_pending_q;

  aes_ctrl_t   aes;
  logic [127:0] aes_out;
  logic        accept;

  assign accept = start && (state_q == StIdle);
  assign busy = (state_q != StIdle);

  ees_aes u_aes (
    .clk_i, .rst_ni,
    .start_i (aes.start),
    .key_i   ({key_hi_q, key_lo_q}),
    .block_i ({NonceTag, 48'd0, 16'(eoff_q[AW-1:4])}),
    .busy_o  (aes.busy),
    .done_o  (aes.done),
    .block_o (aes_out)
  );
  // only window bytes run the core, so no stale run can end under a later item
  assign aes.start = (state_q == StAes) && (kind_q == KindEnc) && !aes.busy && !aes.done &&
                     !ks_pending_q;

  // memory port
  logic          m_we;
  logic [AW-1:0] m_addr;
  logic [7:0]    m_wd, m_rd;
  logic [31:0]   evc_inc;
  logic [1:0]    bk;
  assign evc_inc = evc_q + 32'd1;
  assign bk = 2'(3 - bump_q[1:0]);

  ees_mem #(.AW(AW)) u_mem (
    .clk_i, .we_i(m_we), .addr_i(m_addr), .wdata_i(m_wd), .rdata_o(m_rd)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear: if (clr_q == (AW+1)'(2**AW - 1)) state_d = StIdle;
      StIdle:  if (accept) state_d = StAes;
      StAes:   if (kind_q != KindEnc || aes.done) state_d = StRead;
      StRead:  state_d = StDone;
      StDone:  if (!(last_q && touched_q) || bump_q == 3'd3) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    m_we = 1'b0;
    m_addr = a_q;
    m_wd = wd_q;
    case (state_q)
      StClear: begin
        m_we = 1'b1;
        m_addr = clr_q[AW-1:0];
        m_wd = ErasedByte;
      end
      StRead: begin
        m_we = cmd_q && use_q;
        case (kind_q)
          KindCounter: m_wd = ErasedByte;
          KindEnc:     m_wd = wd_q ^ ks_q;
          default:     m_wd = wd_q;
        endcase
      end
      StDone: if (last_q && touched_q) begin
        m_we = 1'b1;
        m_addr = AW'(cnt_base_q) + AW'(bump_q[1:0]);
        m_wd = evc_inc[8*bk +: 8];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q <= '0;
      bump_q <= '0;
      evc_q <= '0;
      touched_q <= 1'b0;
      res_q <= 1'b0;
      ks_pending_q <= 1'b0;
    end else begin
      state_q <= state_d;
      res_q <= 1'b0;
      if (state_q == StClear) clr_q <= clr_q + 1'b1;
      if (accept) begin
        ks_pending_q <= 1'b0;
        bump_q <= '0;
      end
      if (aes.start) ks_pending_q <= 1'b1;
      if (state_q == StRead && cmd_q && use_q && kind_q == KindCounter) touched_q <= 1'b1;
      if (state_q == StDone) begin
        if (last_q && touched_q) begin
          bump_q <= bump_q + 3'd1;
          if (bump_q == 3'd3) begin
            evc_q <= evc_inc;
            touched_q <= 1'b0;
            res_q <= 1'b1;
          end
        end else begin
          res_q <= 1'b1;
          if (last_q) touched_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= command_i;
      last_q <= burst_last_i;
      use_q <= use_c;
      a_q <= a_c;
      eoff_q <= eoff_c;
      coff_q <= coff_c[1:0];
      wd_q <= write_data_i;
      kind_q <= kind_c;
      ks_q <= '0;
    end
    if (aes.done) ks_q <= aes_out[127 - 8*eoff_q[3:0] -: 8];
    if (state_q == StDone && bump_q == 3'd0) begin
      if (cmd_q || !use_q) rd_data_q <= 8'd0;
      else if (kind_q == KindCounter) rd_data_q <= evc_q[8*(2'(3 - coff_q)) +: 8];
      else rd_data_q <= m_rd ^ ks_q;
    end
    if (state_q == StDone) inc_q <= last_q && touched_q;
  end

  assign result_valid_o = res_q;
  assign read_data_o = rd_data_q;
  assign counter_incremented_o = inc_q;

`ifndef NO_ASSERTIONS
  a_res_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q |=> !res_q) else $error("result held two cycles");
  a_res_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q |-> $past(state_q) == StDone) else $error("result outside done");
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StClear |-> busy) else $error("accept during clear");
  a_bump_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bump_q <= 3'd4) else $error("bump count overrun");
`endif
endmodule
`default_nettype wire

@@ dv/eeprom_scoreboard.sv @@
`default_nettype none
module eeprom_scoreboard import ees_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic        command_i,
  input  wire logic [13:0] start_address_i,
  input  wire logic [5:0]  byte_index_i,
  input  wire logic [7:0]  write_data_i,
  input  wire logic        burst_last_i,
  input  wire logic        result_valid_o,
  input  wire logic [7:0]  read_data_o,
  input  wire logic        counter_incremented_o,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  output int               fail_count,
  output int               pending,
  output int               bump_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] rdata;
    logic       bumped;
  } eeprom_result_t;

  logic [7:0]  sb [256];
  logic [7:0]  mem [16384];
  logic [63:0] key_hi, key_lo;
  logic [13:0] enc_base, cnt_base;
  logic [8:0]  enc_len;
  logic [31:0] evt_cnt;
  logic        cnt_touched;
  eeprom_result_t due_q[$];

  function automatic logic [7:0] dbl(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = dbl(a);
    end
    return p;
  endfunction

  // substitution table built from the field inverse and the affine map
  initial begin
    logic [7:0] inv, r;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h01;
      for (int k = 0; k < 254; k++) inv = gf_mul(inv, x[7:0]);
      if (x == 0) inv = 8'h00;
      r = inv;
      for (int n = 1; n < 5; n++) r ^= (inv << n) | (inv >> (8 - n));
      sb[x] = r ^ 8'h63;
    end
  end

  // keystream byte for window offset off
  function automatic logic [7:0] keystream(input logic [7:0] off);
    logic [7:0] rk [176];
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] rc, a0, a1, a2, a3, tmp, all, f;
    rc = 8'h01;
    for (int i = 0; i < 8; i++) begin
      rk[i]     = key_hi[63 - 8*i -: 8];
      rk[8 + i] = key_lo[63 - 8*i -: 8];
      s[i]      = NonceTag[63 - 8*i -: 8];
      s[8 + i]  = 8'h00;
    end
    s[15] = {4'h0, off[7:4]};
    for (int i = 16; i < 176; i += 4) begin
      a0 = rk[i-4]; a1 = rk[i-3]; a2 = rk[i-2]; a3 = rk[i-1];
      if (i % 16 == 0) begin
        tmp = a0;
        a0 = sb[a1] ^ rc;
        a1 = sb[a2];
        a2 = sb[a3];
        a3 = sb[tmp];
        rc = dbl(rc);
      end
      rk[i]   = rk[i-16] ^ a0;
      rk[i+1] = rk[i-15] ^ a1;
      rk[i+2] = rk[i-14] ^ a2;
      rk[i+3] = rk[i-13] ^ a3;
    end
    for (int i = 0; i < 16; i++) s[i] ^= rk[i];
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) t[i + 4*c] = sb[s[i + 4*((c + i) % 4)]];
      if (r != 10) begin
        for (int c = 0; c < 4; c++) begin
          all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
          f = t[4*c];
          t[4*c]   ^= all ^ dbl(t[4*c] ^ t[4*c+1]);
          t[4*c+1] ^= all ^ dbl(t[4*c+1] ^ t[4*c+2]);
          t[4*c+2] ^= all ^ dbl(t[4*c+2] ^ t[4*c+3]);
          t[4*c+3] ^= all ^ dbl(t[4*c+3] ^ f);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[16*r + i];
    end
    return s[off[3:0]];
  endfunction

  task automatic eeprom_access(input logic cmd, input logic [13:0] sa, input logic [5:0] bi,
                               input logic [7:0] wd, input logic last,
                               output eeprom_result_t res);
    logic [13:0] a, coff, eoff;
    // programs wrap inside the 64-byte page, reads run over the whole space
    a = cmd ? {sa[13:6], sa[5:0] + bi} : sa + {8'h00, bi};
    coff = a - cnt_base;
    eoff = a - enc_base;
    res = '0;
    if (coff < 14'd4) begin
      if (!cmd) res.rdata = evt_cnt[31 - 8*coff[1:0] -: 8];
      else begin
        mem[a] = ErasedByte;
        cnt_touched = 1'b1;
      end
    end else if ({2'b00, eoff} < {7'd0, enc_len}) begin
      if (!cmd) res.rdata = mem[a] ^ keystream(eoff[7:0]);
      else mem[a] = wd ^ keystream(eoff[7:0]);
    end else begin
      if (!cmd) res.rdata = mem[a];
      else mem[a] = wd;
    end
    if (last) begin
      if (cnt_touched) begin
        evt_cnt = evt_cnt + 32'd1;
        for (int k = 0; k < 4; k++) mem[cnt_base + 14'(k)] = evt_cnt[31 - 8*k -: 8];
        res.bumped = 1'b1;
      end
      cnt_touched = 1'b0;
    end
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("%0t: %s got %0h, expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    bump_count = 0;
    key_hi = '0;
    key_lo = '0;
    enc_base = '0;
    enc_len = 9'd252;
    cnt_base = 14'd16380;
    evt_cnt = '0;
    cnt_touched = 1'b0;
    for (int i = 0; i < 16384; i++) mem[i] = ErasedByte;
  end

  always @(posedge clk_i) begin
    eeprom_result_t res, want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegKeyHigh: key_hi = cfg_data_i;
          RegKeyLow:  key_lo = cfg_data_i;
          RegEncBase: enc_base = cfg_data_i[13:0];
          RegEncLen:  enc_len = cfg_data_i[8:0];
          RegCntBase: cnt_base = cfg_data_i[13:0];
          default: ;
        endcase
      end
      if (result_valid_o) begin
        if (due_q.size() == 0) report("unexpected result, read_data", read_data_o, 0);
        else begin
          want = due_q.pop_front();
          if (read_data_o !== want.rdata) report("read_data", read_data_o, want.rdata);
          if (counter_incremented_o !== want.bumped)
            report("counter_incremented", counter_incremented_o, want.bumped);
          if (want.bumped) bump_count++;
        end
      end
      if (start && !busy) begin
        eeprom_access(command_i, start_address_i, byte_index_i, write_data_i, burst_last_i,
                      res);
        due_q.push_back(res);
      end
      pending = due_q.size();
    end
  end
endmodule
`default_nettype wire

@@ dv/tb.sv @@
`default_nettype none
module tb import ees_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // the limit covers the clearing pass plus every item at its worst with its gap
  localparam int CycleLimit = 400000;

  logic        clk_i, rst_ni;
  logic        start, busy;
  logic        command_i, burst_last_i;
  logic [13:0] start_address_i;
  logic [5:0]  byte_index_i;
  logic [7:0]  write_data_i;
  logic        result_valid_o, counter_incremented_o;
  logic [7:0]  read_data_o;
  logic        cfg_valid_i, cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [63:0] cfg_data_i;
  int          fail_count, pending, bump_count;
  int          cycles, items_sent;
  bit          gaps_on;
  logic [13:0] cur_enc_base, cur_cnt_base;

  encrypted_eeprom_store_top u_dut (.*);

  eeprom_scoreboard u_scoreboard (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // valid stays high between back-to-back writes; set_config drops it at the end
  task automatic cfg_write(input reg_idx_e idx, input logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == RegEncBase) cur_enc_base = val[13:0];
    if (idx == RegCntBase) cur_cnt_base = val[13:0];
  endtask

  task automatic set_config(input logic [63:0] khi, input logic [63:0] klo,
                            input logic [13:0] ebase, input logic [8:0] elen,
                            input logic [13:0] cbase);
    cfg_write(RegKeyHigh, khi);
    cfg_write(RegKeyLow, klo);
    cfg_write(RegEncBase, {50'd0, ebase});
    cfg_write(RegEncLen, {55'd0, elen});
    cfg_write(RegCntBase, {50'd0, cbase});
    cfg_valid_i <= 1'b0;
  endtask

  // start stays high between back-to-back transfers; it only drops for a gap or in drain
  task automatic send(input logic cmd, input logic [13:0] sa, input logic [5:0] bi,
                      input logic [7:0] wd, input logic last);
    if (gaps_on && $urandom_range(3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(13, 1)) @(posedge clk_i);
    end
    start           <= 1'b1;
    command_i       <= cmd;
    start_address_i <= sa;
    byte_index_i    <= bi;
    write_data_i    <= wd;
    burst_last_i    <= last;
    do @(posedge clk_i); while (busy);
    items_sent++;
  endtask

  // every item gives a result, so an empty queue plus the counter write-back is idle
  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic burst(input logic cmd, input logic [13:0] sa, input int len);
    for (int i = 0; i < len; i++)
      send(cmd, sa, 6'(i), 8'($urandom), i == len - 1);
  endtask

  // mostly well-formed bursts aimed at the window and counter slots, some noise
  task automatic random_traffic(input int n);
    int done_n, len, pick;
    logic [13:0] sa, last_wr;
    done_n = 0;
    last_wr = '0;
    while (done_n < n) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        send(1'($urandom), 14'($urandom), 6'($urandom), 8'($urandom), 1'($urandom));
        done_n++;
      end else begin
        if (pick < 45) sa = cur_enc_base + 14'($urandom_range(300)) - 14'd16;
        else if (pick < 65) sa = cur_cnt_base + 14'($urandom_range(8)) - 14'd4;
        else sa = 14'($urandom);
        len = ($urandom_range(9) == 0) ? $urandom_range(64, 9) : $urandom_range(8, 1);
        if (pick < 80 && last_wr != 0) begin
          burst(1'b0, last_wr, len); // read back what was programmed
          last_wr = '0;
        end else if ($urandom_range(1)) begin
          burst(1'b1, sa, len);
          last_wr = sa;
        end else burst(1'b0, sa, len);
        // broken burst: trailing byte with no end marker
        if ($urandom_range(15) == 0) begin
          send(1'($urandom), sa, 6'(len), 8'($urandom), 1'b0);
          done_n++;
        end
        done_n += len;
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    command_i = 1'b0;
    start_address_i = '0;
    byte_index_i = '0;
    write_data_i = '0;
    burst_last_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = RegKeyHigh;
    cfg_data_i = '0;
    items_sent = 0;
    gaps_on = 1'b0;
    cur_enc_base = '0;
    cur_cnt_base = 14'd16380;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part under the reset settings
    set_config(64'd0, 64'd0, 14'd0, 9'd252, 14'd16380);
    send(1'b0, 14'd0, 6'd0, 8'h00, 1'b1);          // erased byte in the window
    send(1'b1, 14'd16380, 6'd0, 8'h12, 1'b0);      // counter slot program
    send(1'b1, 14'd16380, 6'd1, 8'hFF, 1'b1);      // ends burst, bump
    burst(1'b0, 14'd16380, 4);                     // counter reads big-endian
    send(1'b1, 14'd60, 6'd0, 8'h00, 1'b0);         // encrypted program, page wrap
    send(1'b1, 14'd60, 6'd3, 8'hFF, 1'b0);
    send(1'b1, 14'd60, 6'd4, 8'hA5, 1'b0);
    send(1'b1, 14'd60, 6'd63, 8'h5A, 1'b1);        // top index lands at 59
    send(1'b0, 14'd60, 6'd0, 8'h00, 1'b0);
    send(1'b0, 14'd0, 6'd0, 8'h00, 1'b0);
    send(1'b0, 14'd59, 6'd0, 8'h00, 1'b1);
    send(1'b0, 14'd16383, 6'd1, 8'h00, 1'b0);      // read wraps the address space
    send(1'b0, 14'd16383, 6'd63, 8'hFF, 1'b1);
    send(1'b1, 14'd16383, 6'd0, 8'h77, 1'b0);      // counter slot inside a burst
    send(1'b0, 14'd16383, 6'd0, 8'h00, 1'b1);      // read ends it: data before bump
    send(1'b1, 14'd300, 6'd0, 8'hFF, 1'b1);        // plain byte
    send(1'b0, 14'd300, 6'd0, 8'h00, 1'b1);
    send(1'b0, 14'd16380, 6'd3, 8'h00, 1'b1);
    drain();

    // window straddling the top of memory, full length, counter at zero
    gaps_on = 1'b1;
    set_config({$urandom, $urandom}, {$urandom, $urandom}, 14'd16300, 9'd256, 14'd0);
    random_traffic(300);
    drain();

    // empty window, all-ones key
    set_config('1, '1, 14'd16383, 9'd0, 14'd16380);
    random_traffic(200);
    drain();

    // random settings; the last stretch runs without gaps
    set_config({$urandom, $urandom}, {$urandom, $urandom}, 14'($urandom),
               9'($urandom_range(256)), 14'($urandom_range(16380)));
    random_traffic(250);
    gaps_on = 1'b0;
    random_traffic(150);
    drain();

    $display("%0d items over four key and window settings, %0d counter bumps seen",
             items_sent, bump_count);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results outstanding", fail_count, pending);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire
